/* hdl/dcdfb_pkg.sv */
// Shared constants for the dirty-cell double framebuffer.
// Depends on nothing; used by the top level and the testbench.
`default_nettype none

package dcdfb_pkg;

    localparam int COLUMNS_DEF = 64;
    localparam int ROWS_DEF    = 32;

    localparam int CELL_W = 32;

    localparam logic [CELL_W-1:0] EMPTY_CELL = '0;

    localparam logic [1:0] MODE_PUT    = 2'd0;
    localparam logic [1:0] MODE_PICK   = 2'd1;
    localparam logic [1:0] MODE_RENDER = 2'd2;

endpackage

`default_nettype wire

/* hdl/dirty_cell_double_framebuffer.sv */
// Top level of the dirty-cell double framebuffer: cell memory, row flag memory, sequencer.
// Depends on dcdfb_pkg.
`default_nettype none

// Text framebuffer of COLUMNS x ROWS cells, each with a next and a current 32-bit slot.
// After reset the block runs a pass that clears the row flag memory row by row and
// accepts no transaction until it is done; cell slots need no clearing because a
// per-cell written bit in the flag memory makes unwritten cells read as empty.
// Put and pick first read the cell and flag memories, then compare and, for a put,
// write back. Render of a row scans one column per cycle, and every dirty cell adds
// a step for its cell memory read; its result then waits while the output register
// is full. A render of a row outside the area returns without results. An output
// register lets the next transaction be accepted while a result still waits to be
// taken.
module dirty_cell_double_framebuffer #(
    parameter int COLUMNS = dcdfb_pkg::COLUMNS_DEF,
    parameter int ROWS    = dcdfb_pkg::ROWS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,

    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_mode,
    input  wire logic [7:0] i_col,
    input  wire logic [7:0] i_row,
    input  wire logic [7:0] i_glyph,
    input  wire logic [7:0] i_fore_color,
    input  wire logic [7:0] i_back_color,
    input  wire logic [7:0] i_style,

    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_accepted,
    output logic [7:0]      o_out_col,
    output logic [7:0]      o_out_row,
    output logic [7:0]      o_out_glyph,
    output logic [7:0]      o_out_fore,
    output logic [7:0]      o_out_back,
    output logic [7:0]      o_out_style,
    output logic            o_run_first,
    output logic            o_run_end,
    output logic            o_last
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int FW    = 3 * COLUMNS;
    localparam int SW    = dcdfb_pkg::CELL_W;

    localparam logic [CW-1:0] LAST_C = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_R = RW'(ROWS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_R_LOAD,
        S_R_SCAN,
        S_R_EMIT,
        S_R_DONE
    } t_state;

    // memories: cell word is {slot_b, slot_a}; flag word is {written, select, dirty}
    logic [2*SW-1:0] m_cell [CELLS];
    logic [FW-1:0]   m_flag [ROWS];

    t_state r_state;

    logic [1:0]         r_mode;
    logic [7:0]         r_col;
    logic [7:0]         r_row;
    logic [SW-1:0]      r_cell;
    logic               r_inside;
    logic [AW-1:0]      r_idx;
    logic [AW-1:0]      r_base;
    logic [CW-1:0]      r_c;
    logic [RW-1:0]      r_clr;
    logic [COLUMNS-1:0] r_valid;
    logic [COLUMNS-1:0] r_sel;
    logic [COLUMNS-1:0] r_dirty;
    logic [COLUMNS-1:0] r_was;

    logic [2*SW-1:0]    r_cell_rd;
    logic [FW-1:0]      r_flag_rd;

    logic               r_out_valid;
    logic               r_out_acc;
    logic [7:0]         r_out_col;
    logic [7:0]         r_out_row;
    logic [SW-1:0]      r_out_cell;
    logic               r_out_first;
    logic               r_out_end;
    logic               r_out_last;

    logic               in_accept;
    logic               in_col_ok;
    logic               in_row_ok;
    logic               in_inside;
    logic [AW-1:0]      in_base;
    logic [AW-1:0]      in_idx;
    logic               out_free;
    logic               out_load;

    logic               cell_rd_en;
    logic [AW-1:0]      cell_rd_addr;
    logic               cell_wr_en;
    logic [2*SW-1:0]    cell_wr_data;
    logic               flag_rd_en;
    logic               flag_wr_en;
    logic [RW-1:0]      flag_wr_addr;
    logic [FW-1:0]      flag_wr_data;

    logic [COLUMNS-1:0] f_valid;
    logic [COLUMNS-1:0] f_sel;
    logic [COLUMNS-1:0] f_dirty;
    logic [CW-1:0]      pc;
    logic               pv;
    logic               ps;
    logic               pd;
    logic [SW-1:0]      slot_a;
    logic [SW-1:0]      slot_b;
    logic [SW-1:0]      nx;
    logic [SW-1:0]      cu;
    logic               put_acc;
    logic               put_wr;
    logic [2*SW-1:0]    put_word;
    logic [COLUMNS-1:0] put_valid;
    logic [COLUMNS-1:0] put_sel;
    logic [COLUMNS-1:0] put_dirty;
    logic [SW-1:0]      pick_val;
    logic               exec_put;

    logic               rv;
    logic               rs;
    logic [SW-1:0]      ren_cell;
    logic [COLUMNS-1:0] was_prev;
    logic [COLUMNS-1:0] was_next;
    logic [COLUMNS-1:0] ren_dirty;
    logic [COLUMNS-1:0] ren_sel;
    logic               ren_last;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_col_ok  = {1'b0, i_col} < 9'(COLUMNS);
    assign in_row_ok  = {1'b0, i_row} < 9'(ROWS);
    assign in_inside  = in_col_ok && in_row_ok;
    assign in_base    = AW'(i_row[RW-1:0]) * AW'(COLUMNS);
    assign in_idx     = in_base + AW'(i_col[CW-1:0]);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign out_load   = out_free && ((r_state == S_EXEC) || (r_state == S_R_EMIT));

    // put / pick evaluation on the read-back cell
    always_comb begin
        f_dirty   = r_flag_rd[COLUMNS-1:0];
        f_sel     = r_flag_rd[2*COLUMNS-1 -: COLUMNS];
        f_valid   = r_flag_rd[FW-1 -: COLUMNS];
        pc        = r_inside ? r_col[CW-1:0] : '0;
        pv        = f_valid[pc];
        ps        = f_sel[pc];
        pd        = f_dirty[pc];
        slot_a    = pv ? r_cell_rd[SW-1:0] : dcdfb_pkg::EMPTY_CELL;
        slot_b    = pv ? r_cell_rd[2*SW-1:SW] : dcdfb_pkg::EMPTY_CELL;
        nx        = ps ? slot_b : slot_a;
        cu        = ps ? slot_a : slot_b;
        pick_val  = pd ? nx : cu;
        put_acc   = 1'b0;
        put_wr    = 1'b0;
        put_word  = {slot_b, slot_a};
        put_valid = f_valid;
        put_sel   = f_sel;
        put_dirty = f_dirty;
        if (nx == r_cell) begin
            put_acc = 1'b0;
        end else if (pd) begin
            put_acc       = 1'b1;
            put_wr        = 1'b1;
            put_word      = ps ? {r_cell, slot_a} : {slot_b, r_cell};
            put_valid[pc] = 1'b1;
        end else if (cu == r_cell) begin
            put_sel[pc]   = ~ps;
            put_dirty[pc] = 1'b0;
        end else begin
            put_acc       = 1'b1;
            put_wr        = 1'b1;
            put_word      = ps ? {r_cell, dcdfb_pkg::EMPTY_CELL}
                               : {dcdfb_pkg::EMPTY_CELL, r_cell};
            put_valid[pc] = 1'b1;
            put_dirty[pc] = 1'b1;
        end
        exec_put = (r_mode == dcdfb_pkg::MODE_PUT) && r_inside;
    end

    // render step on column r_c
    always_comb begin
        rv            = r_valid[r_c];
        rs            = r_sel[r_c];
        ren_cell      = !rv ? dcdfb_pkg::EMPTY_CELL
                      : (rs ? r_cell_rd[2*SW-1:SW] : r_cell_rd[SW-1:0]);
        was_prev      = {r_was[COLUMNS-2:0], 1'b0};
        was_next      = {1'b0, r_was[COLUMNS-1:1]};
        ren_dirty     = r_dirty;
        ren_dirty[r_c] = 1'b0;
        ren_sel       = r_sel;
        ren_sel[r_c]  = ~rs;
        ren_last      = (ren_dirty == '0);
    end

    // memory port control
    always_comb begin
        cell_rd_en   = 1'b0;
        cell_rd_addr = r_base + AW'(r_c);
        cell_wr_en   = 1'b0;
        cell_wr_data = put_word;
        flag_rd_en   = 1'b0;
        flag_wr_en   = 1'b0;
        flag_wr_addr = r_row[RW-1:0];
        flag_wr_data = {r_valid, r_sel, r_dirty};
        unique case (r_state)
            S_CLEAR: begin
                flag_wr_en   = 1'b1;
                flag_wr_addr = r_clr;
                flag_wr_data = '0;
            end
            S_IDLE: begin
                cell_rd_en   = in_accept && in_inside;
                cell_rd_addr = in_idx;
                flag_rd_en   = in_accept && in_row_ok;
            end
            S_EXEC: begin
                cell_wr_en   = out_free && exec_put && put_wr;
                flag_wr_en   = out_free && exec_put;
                flag_wr_data = {put_valid, put_sel, put_dirty};
            end
            S_R_SCAN: begin
                cell_rd_en = r_was[r_c];
            end
            S_R_DONE: begin
                flag_wr_en = 1'b1;
            end
            default: begin
                cell_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cell_wr_en) begin
            m_cell[r_idx] <= cell_wr_data;
        end
        if (cell_rd_en) begin
            r_cell_rd <= m_cell[cell_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (flag_wr_en) begin
            m_flag[flag_wr_addr] <= flag_wr_data;
        end
        if (flag_rd_en) begin
            r_flag_rd <= m_flag[i_row[RW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!i_out_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr == LAST_R) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_mode   <= i_mode;
                        r_col    <= i_col;
                        r_row    <= i_row;
                        r_cell   <= {i_style, i_back_color, i_fore_color, i_glyph};
                        r_inside <= in_inside;
                        r_idx    <= in_idx;
                        r_base   <= in_base;
                        r_c      <= '0;
                        unique case (i_mode)
                            dcdfb_pkg::MODE_PUT, dcdfb_pkg::MODE_PICK: begin
                                r_state <= S_EXEC;
                            end
                            dcdfb_pkg::MODE_RENDER: begin
                                r_state <= in_row_ok ? S_R_LOAD : S_IDLE;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_acc   <= exec_put && put_acc;
                        r_out_col   <= r_col;
                        r_out_row   <= r_row;
                        r_out_cell  <= (r_mode == dcdfb_pkg::MODE_PICK && r_inside)
                                       ? pick_val : dcdfb_pkg::EMPTY_CELL;
                        r_out_first <= 1'b0;
                        r_out_end   <= 1'b0;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_R_LOAD: begin
                    r_dirty <= r_flag_rd[COLUMNS-1:0];
                    r_was   <= r_flag_rd[COLUMNS-1:0];
                    r_sel   <= r_flag_rd[2*COLUMNS-1 -: COLUMNS];
                    r_valid <= r_flag_rd[FW-1 -: COLUMNS];
                    r_state <= S_R_SCAN;
                end
                S_R_SCAN: begin
                    if (r_was[r_c]) begin
                        r_state <= S_R_EMIT;
                    end else if (r_c == LAST_C) begin
                        r_state <= S_R_DONE;
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
                S_R_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_acc   <= 1'b1;
                        r_out_col   <= 8'(r_c);
                        r_out_row   <= r_row;
                        r_out_cell  <= ren_cell;
                        r_out_first <= !was_prev[r_c];
                        r_out_end   <= !was_next[r_c];
                        r_out_last  <= ren_last;
                        r_sel       <= ren_sel;
                        r_dirty     <= ren_dirty;
                        if (r_c == LAST_C) begin
                            r_state <= S_R_DONE;
                        end else begin
                            r_c     <= r_c + 1'b1;
                            r_state <= S_R_SCAN;
                        end
                    end
                end
                S_R_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_out_acc;
    assign o_out_col   = r_out_col;
    assign o_out_row   = r_out_row;
    assign o_out_glyph = r_out_cell[7:0];
    assign o_out_fore  = r_out_cell[15:8];
    assign o_out_back  = r_out_cell[23:16];
    assign o_out_style = r_out_cell[31:24];
    assign o_run_first = r_out_first;
    assign o_run_end   = r_out_end;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

/* hdl/dcdfb_checker.sv */
// Port-level checks for the dirty-cell double framebuffer, bound to its top level.
// Depends on dirty_cell_double_framebuffer.
`default_nettype none

module dcdfb_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic       o_accepted,
    input wire logic [7:0] o_out_col,
    input wire logic [7:0] o_out_glyph,
    input wire logic       o_run_first,
    input wire logic       o_run_end,
    input wire logic       o_last
);

    // stalled transaction stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_out_col) && $stable(o_out_glyph) && $stable(o_last))
        else $error("stalled result changed");

    // run marks come only from render, which always flags its cells
    a_run_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_run_first || o_run_end) |-> o_accepted)
        else $error("run mark on a non-render result");

    // while a render still owes results, no new transaction is taken
    a_busy_mid_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_in_stall && o_accepted)
        else $error("input open before render finished");

endmodule

bind dirty_cell_double_framebuffer dcdfb_checker u_dcdfb_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for dirty_cell_double_framebuffer: directed table, then random
// put/pick/render traffic with bursty input and a stalling output, checked by a predictor.
// Depends on dcdfb_pkg and the dirty_cell_double_framebuffer RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int COLUMNS = 64;
    localparam int ROWS = 32;
    localparam int CELLS = COLUMNS * ROWS;
    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER = 150;
    localparam int IDLE_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 2 * COLUMNS + 20;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] glyph;
        logic [7:0] fore;
        logic [7:0] back;
        logic [7:0] style;
    } t_cmd;

    typedef struct packed {
        logic        accepted;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [31:0] word;
        logic        run_first;
        logic        run_end;
        logic        last;
    } t_cell_report;

    typedef struct {
        t_cmd        cmd;
        bit          known;
        bit          exp_acc;
        logic [31:0] exp_word;
    } t_table_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [1:0] i_mode;
    logic [7:0] i_col;
    logic [7:0] i_row;
    logic [7:0] i_glyph;
    logic [7:0] i_fore_color;
    logic [7:0] i_back_color;
    logic [7:0] i_style;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_accepted;
    logic [7:0] o_out_col;
    logic [7:0] o_out_row;
    logic [7:0] o_out_glyph;
    logic [7:0] o_out_fore;
    logic [7:0] o_out_back;
    logic [7:0] o_out_style;
    logic       o_run_first;
    logic       o_run_end;
    logic       o_last;

    dirty_cell_double_framebuffer #(
        .COLUMNS(COLUMNS),
        .ROWS(ROWS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_mode(i_mode),
        .i_col(i_col),
        .i_row(i_row),
        .i_glyph(i_glyph),
        .i_fore_color(i_fore_color),
        .i_back_color(i_back_color),
        .i_style(i_style),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_accepted(o_accepted),
        .o_out_col(o_out_col),
        .o_out_row(o_out_row),
        .o_out_glyph(o_out_glyph),
        .o_out_fore(o_out_fore),
        .o_out_back(o_out_back),
        .o_out_style(o_out_style),
        .o_run_first(o_run_first),
        .o_run_end(o_run_end),
        .o_last(o_last)
    );

    logic [31:0]  slot_a [CELLS];
    logic [31:0]  slot_b [CELLS];
    bit           next_is_b [CELLS];
    bit           dirty [CELLS];
    t_cell_report cell_report_q[$];
    t_table_row   stim_table[$];
    logic [31:0]  palette [4];
    int           mismatch_cnt = 0;
    int           items_sent = 0;
    int           burst_left = 0;
    int           idle_cycles = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Predictor: applies one transaction to the model state, queues its results if asked.
    function automatic void framebuffer_apply(input t_cmd c, input bit record);
        logic [31:0]  word;
        logic [31:0]  nx;
        logic [31:0]  cu;
        bit           in_area;
        int           idx;
        int           base;
        int           last_col;
        bit           was_dirty [COLUMNS];
        t_cell_report r;
        word = {c.style, c.back, c.fore, c.glyph};
        in_area = (c.col < COLUMNS) && (c.row < ROWS);
        idx = in_area ? c.row * COLUMNS + c.col : 0;
        r = '0;
        r.col = c.col;
        r.row = c.row;
        r.last = 1'b1;
        case (c.mode)
            dcdfb_pkg::MODE_PUT: begin
                if (in_area) begin
                    nx = next_is_b[idx] ? slot_b[idx] : slot_a[idx];
                    cu = next_is_b[idx] ? slot_a[idx] : slot_b[idx];
                    if (nx == word) begin
                        r.accepted = 1'b0;
                    end else if (dirty[idx]) begin
                        if (next_is_b[idx]) slot_b[idx] = word; else slot_a[idx] = word;
                        r.accepted = 1'b1;
                    end else if (cu == word) begin
                        next_is_b[idx] = !next_is_b[idx];
                        dirty[idx] = 1'b0;
                    end else begin
                        if (next_is_b[idx]) begin
                            slot_b[idx] = word;
                            slot_a[idx] = dcdfb_pkg::EMPTY_CELL;
                        end else begin
                            slot_a[idx] = word;
                            slot_b[idx] = dcdfb_pkg::EMPTY_CELL;
                        end
                        dirty[idx] = 1'b1;
                        r.accepted = 1'b1;
                    end
                end
                if (record) cell_report_q.push_back(r);
            end
            dcdfb_pkg::MODE_PICK: begin
                if (in_area) begin
                    if (dirty[idx] == next_is_b[idx]) r.word = slot_b[idx];
                    else r.word = slot_a[idx];
                end
                if (record) cell_report_q.push_back(r);
            end
            dcdfb_pkg::MODE_RENDER: begin
                if (c.row < ROWS) begin
                    base = c.row * COLUMNS;
                    last_col = -1;
                    for (int k = 0; k < COLUMNS; k++) begin
                        was_dirty[k] = dirty[base + k];
                        if (was_dirty[k]) last_col = k;
                    end
                    for (int k = 0; k < COLUMNS; k++) begin
                        if (was_dirty[k]) begin
                            r = '0;
                            r.accepted = 1'b1;
                            r.col = 8'(k);
                            r.row = c.row;
                            r.word = next_is_b[base + k] ? slot_b[base + k] : slot_a[base + k];
                            r.run_first = (k == 0) || !was_dirty[k - 1];
                            r.run_end = (k == COLUMNS - 1) || !was_dirty[k + 1];
                            r.last = (k == last_col);
                            next_is_b[base + k] = !next_is_b[base + k];
                            dirty[base + k] = 1'b0;
                            if (record) cell_report_q.push_back(r);
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_cmd make_cmd(input logic [1:0] mode, input logic [7:0] col,
                                      input logic [7:0] row, input logic [31:0] word);
        t_cmd c;
        c.mode = mode;
        c.col = col;
        c.row = row;
        {c.style, c.back, c.fore, c.glyph} = word;
        return c;
    endfunction

    task automatic add_row(input logic [1:0] mode, input logic [7:0] col, input logic [7:0] row,
                           input logic [31:0] word, input bit known, input bit exp_acc,
                           input logic [31:0] exp_word);
        t_table_row t;
        t.cmd = make_cmd(mode, col, row, word);
        t.known = known;
        t.exp_acc = exp_acc;
        t.exp_word = exp_word;
        stim_table.push_back(t);
    endtask

    // Offers one transaction, inserting a random gap at each burst boundary.
    task automatic offer(input t_cmd c, input bit known, input bit exp_acc,
                         input logic [31:0] exp_word);
        int gap;
        t_cell_report r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_mode <= c.mode;
        i_col <= c.col;
        i_row <= c.row;
        i_glyph <= c.glyph;
        i_fore_color <= c.fore;
        i_back_color <= c.back;
        i_style <= c.style;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        framebuffer_apply(c, !known);
        if (known) begin
            r = '0;
            r.accepted = exp_acc;
            r.col = c.col;
            r.row = c.row;
            r.word = exp_word;
            r.last = 1'b1;
            cell_report_q.push_back(r);
        end
        if (c.mode != MODE_UNUSED) items_sent++;
    endtask

    function automatic logic [31:0] pick_word();
        if ($urandom_range(0, 9) < 6) return palette[$urandom_range(0, 3)];
        return $urandom;
    endfunction

    task automatic random_txn();
        int          kind;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [7:0]  fill_row;
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 85) begin
            col = 8'($urandom_range(0, COLUMNS - 1));
            row = 8'($urandom_range(0, 3));
        end else begin
            col = 8'($urandom_range(0, 255));
            row = 8'($urandom_range(0, 255));
        end
        if (kind < 2) begin
            offer(make_cmd(MODE_UNUSED, 8'($urandom), 8'($urandom), $urandom),
                  1'b0, 1'b0, '0);
        end else if (kind < 50) begin
            offer(make_cmd(dcdfb_pkg::MODE_PUT, col, row, pick_word()), 1'b0, 1'b0, '0);
        end else if (kind < 75) begin
            offer(make_cmd(dcdfb_pkg::MODE_PICK, col, row, $urandom), 1'b0, 1'b0, '0);
        end else if (kind < 98) begin
            offer(make_cmd(dcdfb_pkg::MODE_RENDER, 8'($urandom), row, $urandom),
                  1'b0, 1'b0, '0);
        end else begin
            fill_row = 8'($urandom_range(0, 3));
            for (int k = 0; k < COLUMNS; k++)
                offer(make_cmd(dcdfb_pkg::MODE_PUT, 8'(k), fill_row, pick_word()),
                      1'b0, 1'b0, '0);
            offer(make_cmd(dcdfb_pkg::MODE_RENDER, 8'($urandom), fill_row, $urandom),
                  1'b0, 1'b0, '0);
        end
    endtask

    // Receiver: random stall phases plus one long hold-off to back up the block.
    initial begin
        bit held_off;
        int phase_left;
        int phase_kind;
        held_off = 1'b0;
        phase_left = 0;
        phase_kind = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_off && items_sent >= HOLD_AFTER) begin
                held_off = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                if (phase_left == 0) begin
                    phase_left = $urandom_range(5, 60);
                    phase_kind = $urandom_range(0, 2);
                end
                phase_left--;
                case (phase_kind)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    default: i_out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_cell_report got;
        t_cell_report exp;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            got.accepted = o_accepted;
            got.col = o_out_col;
            got.row = o_out_row;
            got.word = {o_out_style, o_out_back, o_out_fore, o_out_glyph};
            got.run_first = o_run_first;
            got.run_end = o_run_end;
            got.last = o_last;
            if (cell_report_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result: col=%0d row=%0d cell=%08h", got.col, got.row,
                             got.word);
            end else begin
                exp = cell_report_q.pop_front();
                if (got !== exp) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("exp: acc=%0d col=%0d row=%0d cell=%08h f=%0d e=%0d l=%0d",
                                 exp.accepted, exp.col, exp.row, exp.word, exp.run_first,
                                 exp.run_end, exp.last);
                        $display("got: acc=%0d col=%0d row=%0d cell=%08h f=%0d e=%0d l=%0d",
                                 got.accepted, got.col, got.row, got.word, got.run_first,
                                 got.run_end, got.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid === 1'b1 && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_mode = dcdfb_pkg::MODE_PUT;
        i_col = '0;
        i_row = '0;
        i_glyph = '0;
        i_fore_color = '0;
        i_back_color = '0;
        i_style = '0;
        for (int k = 0; k < CELLS; k++) begin
            slot_a[k] = dcdfb_pkg::EMPTY_CELL;
            slot_b[k] = dcdfb_pkg::EMPTY_CELL;
            next_is_b[k] = 1'b0;
            dirty[k] = 1'b0;
        end
        palette[0] = dcdfb_pkg::EMPTY_CELL;
        palette[1] = 32'hFFFF_FFFF;
        palette[2] = 32'h0102_0341;
        palette[3] = 32'h8000_7F20;

        // directed: empty after reset, three of the four put cases, area edges, row-end runs
        add_row(dcdfb_pkg::MODE_PICK,   8'd0,   8'd0,   32'h0,
                1'b1, 1'b0, dcdfb_pkg::EMPTY_CELL);
        add_row(dcdfb_pkg::MODE_PICK,   8'd63,  8'd31,  32'hFFFF_FFFF,
                1'b1, 1'b0, dcdfb_pkg::EMPTY_CELL);
        add_row(dcdfb_pkg::MODE_PUT,    8'd0,   8'd0,   dcdfb_pkg::EMPTY_CELL,
                1'b1, 1'b0, dcdfb_pkg::EMPTY_CELL);
        add_row(dcdfb_pkg::MODE_PUT,    8'd0,   8'd0,   32'hFFFF_FFFF,
                1'b1, 1'b1, dcdfb_pkg::EMPTY_CELL);
        add_row(dcdfb_pkg::MODE_PUT,    8'd0,   8'd0,   32'h1234_5678,
                1'b1, 1'b1, dcdfb_pkg::EMPTY_CELL);
        add_row(dcdfb_pkg::MODE_PICK,   8'd0,   8'd0,   32'h0,
                1'b1, 1'b0, 32'h1234_5678);
        add_row(dcdfb_pkg::MODE_PUT,    8'd0,   8'd0,   32'h1234_5678,
                1'b1, 1'b0, dcdfb_pkg::EMPTY_CELL);
        add_row(dcdfb_pkg::MODE_PUT,    8'd1,   8'd0,   32'hA5A5_A5A5,
                1'b1, 1'b1, dcdfb_pkg::EMPTY_CELL);
        add_row(dcdfb_pkg::MODE_PUT,    8'd2,   8'd0,   32'h5A5A_5A5A,
                1'b1, 1'b1, dcdfb_pkg::EMPTY_CELL);
        add_row(dcdfb_pkg::MODE_PUT,    8'd63,  8'd0,   32'h80FF_0001,
                1'b1, 1'b1, dcdfb_pkg::EMPTY_CELL);
        add_row(dcdfb_pkg::MODE_PUT,    8'd64,  8'd0,   32'h0000_0011,
                1'b1, 1'b0, dcdfb_pkg::EMPTY_CELL);
        add_row(dcdfb_pkg::MODE_PUT,    8'd0,   8'd32,  32'h0000_0011,
                1'b1, 1'b0, dcdfb_pkg::EMPTY_CELL);
        add_row(dcdfb_pkg::MODE_PUT,    8'd255, 8'd255, 32'hFFFF_FFFF,
                1'b1, 1'b0, dcdfb_pkg::EMPTY_CELL);
        add_row(dcdfb_pkg::MODE_PICK,   8'd255, 8'd255, 32'hFFFF_FFFF,
                1'b1, 1'b0, dcdfb_pkg::EMPTY_CELL);
        add_row(dcdfb_pkg::MODE_RENDER, 8'd255, 8'd0,   32'hFFFF_FFFF,
                1'b0, 1'b0, dcdfb_pkg::EMPTY_CELL);
        add_row(dcdfb_pkg::MODE_PICK,   8'd0,   8'd0,   32'h0,
                1'b0, 1'b0, dcdfb_pkg::EMPTY_CELL);
        add_row(dcdfb_pkg::MODE_PUT,    8'd1,   8'd0,   32'h0,
                1'b0, 1'b0, dcdfb_pkg::EMPTY_CELL);
        add_row(dcdfb_pkg::MODE_PUT,    8'd2,   8'd0,   32'hA5A5_A5A5,
                1'b0, 1'b0, dcdfb_pkg::EMPTY_CELL);
        add_row(dcdfb_pkg::MODE_RENDER, 8'd0,   8'd0,   32'h0,
                1'b0, 1'b0, dcdfb_pkg::EMPTY_CELL);
        add_row(dcdfb_pkg::MODE_RENDER, 8'd0,   8'd32,  32'h0,
                1'b0, 1'b0, dcdfb_pkg::EMPTY_CELL);
        add_row(dcdfb_pkg::MODE_RENDER, 8'd0,   8'd255, 32'h0,
                1'b0, 1'b0, dcdfb_pkg::EMPTY_CELL);
        add_row(MODE_UNUSED,            8'd255, 8'd255, 32'hFFFF_FFFF,
                1'b0, 1'b0, dcdfb_pkg::EMPTY_CELL);
        add_row(dcdfb_pkg::MODE_PUT,    8'd62,  8'd31,  32'h0000_FF00,
                1'b0, 1'b0, dcdfb_pkg::EMPTY_CELL);
        add_row(dcdfb_pkg::MODE_PUT,    8'd63,  8'd31,  32'h00FF_0000,
                1'b0, 1'b0, dcdfb_pkg::EMPTY_CELL);
        add_row(dcdfb_pkg::MODE_RENDER, 8'd0,   8'd31,  32'h0,
                1'b0, 1'b0, dcdfb_pkg::EMPTY_CELL);

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[k])
            offer(stim_table[k].cmd, stim_table[k].known, stim_table[k].exp_acc,
                  stim_table[k].exp_word);
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) random_txn();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (cell_report_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && cell_report_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
